/* hw/rtl/gtb_pkg.sv */
// Shared package for the glyph-to-bitmap blitter.
// Holds the default glyph geometry, command codes, special codes and state type.
// Used by the blitter top level and its port checker.
`timescale 1ns / 1ps

package gtb_pkg;

  localparam int GLYPH_WIDTH_DEF  = 8;
  localparam int GLYPH_HEIGHT_DEF = 8;
  localparam int GLYPH_COUNT_DEF  = 256;

  localparam logic [1:0] CMD_DRAW      = 2'd0;
  localparam logic [1:0] CMD_GLYPH_ROW = 2'd1;
  localparam logic [1:0] CMD_MAP       = 2'd2;
  localparam logic [1:0] CMD_SPACE_ROW = 2'd3;

  localparam logic [7:0]  SPACE_CODE   = 8'd32;
  localparam logic [7:0]  SPACE_SET    = 8'hFF;
  localparam logic [11:0] STRIDE_RESET = 12'd640;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LOAD,
    ST_DRAW
  } state_t;

endpackage

/* hw/rtl/glyph_to_bitmap_blitter_unit.sv */
// Top level of the glyph-to-bitmap blitter: glyph, map and space memories,
// the draw sequencer and the pixel output register. Depends on gtb_pkg.
`timescale 1ns / 1ps

// Load requests (glyph row, map entry, space row) do not stall the input. A
// draw request for a mapped character first reads the character map, then
// fetches the glyph rows from memory into a row buffer, and then walks the
// cell one pixel position per cycle, emitting one write per set pixel. The
// walk ends at the last set pixel, and a stalled output holds the walk. A
// space draw skips the map read and runs only when font_set is SPACE_SET.
// New requests are taken only between draws, while a finished write may still
// wait at the output.
module glyph_to_bitmap_blitter_unit #(
  parameter int GLYPH_WIDTH  = gtb_pkg::GLYPH_WIDTH_DEF,
  parameter int GLYPH_HEIGHT = gtb_pkg::GLYPH_HEIGHT_DEF,
  parameter int GLYPH_COUNT  = gtb_pkg::GLYPH_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [11:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [7:0]  char_code,
  input  logic [10:0] pos_x,
  input  logic [10:0] pos_y,
  input  logic [7:0]  color,
  input  logic [7:0]  font_set,
  input  logic [7:0]  glyph_index,
  input  logic [2:0]  glyph_row,
  input  logic [7:0]  row_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] pixel_offset,
  output logic [7:0]  pixel_color,
  output logic        last
);

  import gtb_pkg::*;

  localparam int GIDX_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam int ADDR_W = GIDX_W + 3;
  localparam int DEPTH  = GLYPH_COUNT * 8;
  localparam logic [7:0] COL_MASK  = 8'((9'd1 << GLYPH_WIDTH) - 9'd1);
  localparam logic [2:0] ROW_LAST  = 3'(GLYPH_HEIGHT - 1);
  localparam logic [2:0] COL_LAST  = 3'(GLYPH_WIDTH - 1);
  localparam logic [3:0] ROW_COUNT = 4'(GLYPH_HEIGHT);
  localparam logic [8:0] GCOUNT    = 9'(GLYPH_COUNT);

  logic [7:0] glyph_mem [0:DEPTH-1];
  logic [7:0] map_mem [0:255];
  logic [7:0] space_mem [0:7];
  logic [7:0] glyph_q;
  logic [7:0] map_q;
  logic [7:0] space_q;

  state_t state;
  state_t state_next;

  logic [11:0] line_stride;
  logic [23:0] row_base;
  logic [7:0]  color_reg;
  logic        src_space;
  logic [GIDX_W-1:0] gidx;
  logic [3:0]  issue_row;
  logic        cap_valid;
  logic [2:0]  cap_row;
  logic        any_set;
  logic [2:0]  last_row;
  logic [7:0]  row_buf [0:7];
  logic [2:0]  row;
  logic [2:0]  col;

  logic        accept;
  logic        is_space;
  logic        map_ok;
  logic [7:0]  cap_bits;
  logic        load_done;
  logic        load_any;
  logic [7:0]  cur_bits;
  logic        pix_set;
  logic        pix_last;
  logic        out_free;
  logic        emit;
  logic        step;
  logic        enter_load;
  logic [22:0] y_product;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;

  assign accept    = in_valid && !in_stall;
  assign is_space  = (char_code == SPACE_CODE);
  assign map_ok    = ({1'b0, map_q} < GCOUNT);
  assign cap_bits  = (src_space ? space_q : glyph_q) & COL_MASK;
  assign load_done = cap_valid && (cap_row == ROW_LAST);
  assign load_any  = any_set || (cap_bits != 8'd0);
  assign cur_bits  = row_buf[row];
  assign pix_set   = cur_bits[col];
  assign pix_last  = (row == last_row) && ((cur_bits & (8'hFE << col)) == 8'd0);
  assign out_free  = !out_valid || !out_stall;
  assign y_product = pos_y * line_stride;
  assign rd_addr   = ADDR_W'({gidx, issue_row[2:0]});
  assign wr_addr   = ADDR_W'({glyph_index[GIDX_W-1:0], glyph_row});

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && cmd == CMD_DRAW) begin
          if (!is_space) begin
            state_next = ST_CHECK;
          end else if (font_set == SPACE_SET) begin
            state_next = ST_LOAD;
          end
        end
      end
      ST_CHECK: begin
        state_next = map_ok ? ST_LOAD : ST_IDLE;
      end
      ST_LOAD: begin
        if (load_done) begin
          state_next = load_any ? ST_DRAW : ST_IDLE;
        end
      end
      ST_DRAW: begin
        if (emit && pix_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = (state != ST_IDLE);
    emit       = (state == ST_DRAW) && pix_set && out_free;
    step       = (state == ST_DRAW) && (!pix_set || out_free);
    enter_load = (state_next == ST_LOAD) && (state != ST_LOAD);
  end

  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_GLYPH_ROW && ({1'b0, glyph_index} < GCOUNT)) begin
      glyph_mem[wr_addr] <= row_bits;
    end
    glyph_q <= glyph_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_MAP) begin
      map_mem[char_code] <= glyph_index;
    end
    map_q <= map_mem[char_code];
  end

  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_SPACE_ROW) begin
      space_mem[glyph_row] <= row_bits;
    end
    space_q <= space_mem[issue_row[2:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      line_stride <= STRIDE_RESET;
      out_valid   <= 1'b0;
      cap_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        line_stride <= cfg_wr_data;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (enter_load) begin
        cap_valid <= 1'b0;
      end else if (state == ST_LOAD) begin
        cap_valid <= (issue_row < ROW_COUNT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_DRAW) begin
      row_base  <= 24'(y_product) + 24'(pos_x);
      color_reg <= color;
      src_space <= is_space;
    end
    if (state == ST_CHECK) begin
      gidx <= map_q[GIDX_W-1:0];
    end
    if (enter_load) begin
      issue_row <= 4'd0;
      any_set   <= 1'b0;
    end else if (state == ST_LOAD) begin
      if (issue_row < ROW_COUNT) begin
        issue_row <= issue_row + 4'd1;
      end
      cap_row <= issue_row[2:0];
      if (cap_valid) begin
        row_buf[cap_row] <= cap_bits;
        if (cap_bits != 8'd0) begin
          any_set  <= 1'b1;
          last_row <= cap_row;
        end
      end
    end
    if (state == ST_LOAD && load_done) begin
      row <= 3'd0;
      col <= 3'd0;
    end else if (step) begin
      if (col == COL_LAST) begin
        col      <= 3'd0;
        row      <= row + 3'd1;
        row_base <= row_base + 24'(line_stride);
      end else begin
        col <= col + 3'd1;
      end
    end
    if (emit) begin
      pixel_offset <= row_base + 24'(col);
      pixel_color  <= color_reg;
      last         <= pix_last;
    end
  end

endmodule

/* hw/rtl/gtb_checker.sv */
// Port-level checker for the glyph-to-bitmap blitter, bound to its top level.
// Depends on gtb_pkg for the command codes.
`timescale 1ns / 1ps

module gtb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  cmd,
  input logic        out_valid,
  input logic        out_stall,
  input logic [23:0] pixel_offset,
  input logic [7:0]  pixel_color,
  input logic        last
);

  import gtb_pkg::*;

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Output valid after reset.");

  a_stalled_write_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_offset) &&
      $stable(pixel_color) && $stable(last))
    else $error("Stalled pixel write changed.");

  a_busy_only_after_draw: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(in_valid && cmd == CMD_DRAW))
    else $error("Input stalled without a draw request.");

  a_load_never_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && cmd != CMD_DRAW |=> !in_stall)
    else $error("Load request left the input stalled.");

  a_draw_busy_until_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> in_stall)
    else $error("Draw ended before its final pixel write.");

endmodule

bind glyph_to_bitmap_blitter_unit gtb_checker u_checker (.*);
